[rtl/core/pulse_period_speed_meter_macros.svh]
// Assertion macros for the pulse period speed meter.
// Used by the top level only; needs nothing else.
`ifndef PULSE_PERIOD_SPEED_METER_MACROS_SVH
`define PULSE_PERIOD_SPEED_METER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPSM_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPSM_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

[rtl/core/ppsm_pkg.sv]
// Types and constants shared by the pulse period speed meter modules.
// Depends on nothing.
package ppsm_pkg;

  localparam int TS_W        = 32;
  localparam int SPEED_W     = 20;
  localparam int PPNM_W      = 16;
  localparam int DIV_W       = 48;
  localparam int DIV_STEP_W  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_PULSE  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [DIV_STEP_W-1:0] PERIOD_STEPS = DIV_STEP_W'(TS_W);
  localparam logic [DIV_STEP_W-1:0] SPEED_STEPS  = DIV_STEP_W'(41);
  localparam logic [DIV_W-1:0]      MM_NUMERATOR = DIV_W'(64'd1852000000000);
  localparam logic [SPEED_W-1:0]    SPEED_MAX    = '1;
  localparam logic [PPNM_W-1:0]     PPNM_RESET   = PPNM_W'(20000);

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_mm_per_s;
    logic [TS_W-1:0]    mean_period_us;
    logic [TS_W-1:0]    pulses_counted;
  } result_t;

  typedef struct packed {
    logic            report;
    logic [TS_W-1:0] timestamp;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_W-1:0]      dividend;
    logic [DIV_W-1:0]      divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/pulse_period_speed_meter.sv]
// Top level of the pulse period speed meter: configuration register and wiring.
// Depends on ppsm_pkg, ppsm_front, ppsm_queue, ppsm_back and ppsm_divider.
//
//   Channel   Direction  Handshake          Beat
//   item      in         item_valid/stall   in_item_t: operation, timestamp_us
//   result    out        result_valid/stall result_t: speed, mean period, count
//   cfg       in         cfg_valid/ready    cfg_data: pulses per nautical mile
//
// A pulse beat is taken without leaving S_IDLE, so pulses stream at one per cycle
// while the queue has room. A report with intervals counted holds the back end
// while the shared one-bit-per-cycle divider runs 32 steps for the mean period
// and, for a nonzero product, 41 steps for the speed, then emits its result beat.
// Reset clears the queue, the accumulators and the result valid flag at once.
// Up to three item beats wait while the back end divides or the result stalls.
`include "pulse_period_speed_meter_macros.svh"

module pulse_period_speed_meter import ppsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PPNM_W-1:0] cfg_data
);

  logic [PPNM_W-1:0] ppnm;
  logic              push;
  cmd_t              push_cmd;
  logic              queue_full;
  logic              head_valid;
  cmd_t              head;
  logic              pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppnm <= PPNM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ppnm <= cfg_data;
    end
  end

  ppsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ppsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ppsm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ppsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ppnm         (ppnm),
    .cmd_valid    (head_valid),
    .cmd          (head),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `PPSM_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !queue_full, "push into a full queue")
  `PPSM_ASSERT_IMPL(a_no_start_when_busy, clk, rst, div_req.start, !div_rsp.busy, "divider busy")
  `PPSM_ASSERT_NEXT(a_start_sets_busy, clk, rst, div_req.start, div_rsp.busy, "divider idle")

endmodule

[rtl/core/ppsm_front.sv]
// Input stage: takes item beats and classifies them into commands.
// Depends on ppsm_pkg; feeds ppsm_queue.
module ppsm_front import ppsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic held;
  cmd_t held_cmd;
  logic take;

  assign item_stall = held && queue_full;
  assign take       = item_valid && !item_stall;
  assign push       = held && !queue_full;
  assign push_cmd   = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_cmd.report    <= (item.operation == OP_REPORT);
      held_cmd.timestamp <= item.timestamp_us;
    end
  end

endmodule

[rtl/core/ppsm_queue.sv]
// Short command queue between the front stage and the back end.
// Depends on ppsm_pkg.
module ppsm_queue import ppsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/ppsm_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on ppsm_pkg; shared by both report divisions.
module ppsm_divider import ppsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      quo;
  logic [DIV_W-1:0]      dsr;
  logic [DIV_W:0]        rem_sh;
  logic [DIV_W:0]        diff;
  logic                  fits;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign fits   = !diff[DIV_W];
  assign rsp    = '{busy: busy, done: done, quotient: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == DIV_STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend << (DIV_STEP_W'(DIV_W) - req.steps);
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

[rtl/core/ppsm_back.sv]
// Back end: interval accumulators, report sequencer and result register.
// Depends on ppsm_pkg; drives ppsm_divider through its request and response ports.
module ppsm_back import ppsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PPNM_W-1:0] ppnm,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DIV_PERIOD = 6'b000010,
    S_MUL        = 6'b000100,
    S_CHECK      = 6'b001000,
    S_DIV_SPEED  = 6'b010000,
    S_DONE       = 6'b100000
  } state_t;

  state_t                state;
  logic [TS_W-1:0]       last_pulse_time;
  logic [TS_W-1:0]       interval_sum;
  logic [TS_W-1:0]       interval_count;
  logic [TS_W-1:0]       rep_count;
  logic [TS_W-1:0]       period;
  logic [DIV_W-1:0]      product;
  logic [SPEED_W-1:0]    speed;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic [DIV_STEP_W-1:0] div_steps;
  logic                  res_valid;
  result_t               res;

  logic                  take_pulse;
  logic                  take_report;
  logic                  later;
  logic [TS_W:0]         sum_add;
  logic [TS_W:0]         count_add;
  logic [TS_W-1:0]       sum_next;
  logic [TS_W-1:0]       count_next;
  logic                  can_emit;

  assign pop         = (state == S_IDLE) && cmd_valid;
  assign take_pulse  = pop && !cmd.report;
  assign take_report = pop && cmd.report;
  assign later       = cmd.timestamp > last_pulse_time;
  assign sum_add     = {1'b0, interval_sum} + {1'b0, cmd.timestamp - last_pulse_time};
  assign count_add   = {1'b0, interval_count} + (TS_W + 1)'(1);
  assign sum_next    = sum_add[TS_W] ? '1 : sum_add[TS_W-1:0];
  assign count_next  = count_add[TS_W] ? '1 : count_add[TS_W-1:0];
  assign can_emit    = !res_valid || !result_stall;

  assign div_req      = '{start: div_start, dividend: div_dividend,
                          divisor: div_divisor, steps: div_steps};
  assign result_valid = res_valid;
  assign result       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_pulse_time <= '1;
      interval_sum    <= '0;
      interval_count  <= '0;
      div_start       <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      div_start <= (take_report && (interval_count != '0)) ||
                   ((state == S_CHECK) && (product != '0));
      if ((state == S_DONE) && can_emit) begin
        res_valid <= 1'b1;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_pulse) begin
            if (later) begin
              interval_sum   <= sum_next;
              interval_count <= count_next;
            end
            last_pulse_time <= cmd.timestamp;
          end else if (take_report) begin
            interval_sum   <= '0;
            interval_count <= '0;
            if (interval_count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV_PERIOD;
            end
          end
        end
        S_DIV_PERIOD: begin
          if (div_rsp.done) begin
            state <= (div_rsp.quotient == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (product == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV_SPEED;
          end
        end
        S_DIV_SPEED: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take_report) begin
          rep_count    <= interval_count;
          period       <= '0;
          speed        <= '0;
          div_dividend <= DIV_W'(interval_sum);
          div_divisor  <= DIV_W'(interval_count);
          div_steps    <= PERIOD_STEPS;
        end
      end
      S_DIV_PERIOD: begin
        if (div_rsp.done) begin
          period <= div_rsp.quotient[TS_W-1:0];
          speed  <= '0;
        end
      end
      S_MUL: begin
        product <= DIV_W'(ppnm) * DIV_W'(period);
      end
      S_CHECK: begin
        speed        <= SPEED_MAX;
        div_dividend <= MM_NUMERATOR;
        div_divisor  <= product;
        div_steps    <= SPEED_STEPS;
      end
      S_DIV_SPEED: begin
        if (div_rsp.done) begin
          speed <= (div_rsp.quotient[DIV_W-1:SPEED_W] != '0)
                   ? SPEED_MAX : div_rsp.quotient[SPEED_W-1:0];
        end
      end
      S_DONE: begin
        if (can_emit) begin
          res.speed_mm_per_s <= speed;
          res.mean_period_us <= period;
          res.pulses_counted <= rep_count;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pulse_period_speed_meter: pulse and report beats
// go in, every report result is checked against a predictor of the tachometer.
// Depends on ppsm_pkg and the pulse_period_speed_meter RTL.
module tb_top;
  import ppsm_pkg::*;

  localparam logic [63:0] MM_PER_NMI_SCALED = 64'd1852000000000;
  localparam int          SETTLE_CYCLES     = 200;
  localparam int          DRAIN_GUARD       = 50000;
  localparam int          HOLD_CYCLES       = 600;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  in_item_t          item_beat    = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result_beat;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [PPNM_W-1:0] cfg_data     = '0;

  logic [PPNM_W-1:0] ppnm_setting;
  logic [TS_W-1:0]   last_pulse_ts;
  logic [TS_W-1:0]   interval_total;
  logic [TS_W-1:0]   interval_count;
  logic [TS_W-1:0]   wheel_clock;

  result_t pending_reports[$];
  result_t want;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;
  int beats_sent      = 0;
  int reports_checked = 0;
  int cfg_writes      = 0;
  int mismatches      = 0;

  pulse_period_speed_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [TS_W-1:0] sat_add32(input logic [TS_W-1:0] a,
                                               input logic [TS_W-1:0] b);
    logic [TS_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[TS_W] ? '1 : total[TS_W-1:0];
  endfunction

  function automatic void reset_tach();
    ppnm_setting   = PPNM_W'(20000);
    last_pulse_ts  = '1;
    interval_total = '0;
    interval_count = '0;
  endfunction

  function automatic bit advance_tach(input in_item_t beat, output result_t report);
    logic [63:0] period;
    logic [63:0] speed;
    logic [63:0] divisor;
    report = '0;
    if (beat.operation == OP_PULSE) begin
      if (beat.timestamp_us > last_pulse_ts) begin
        interval_total = sat_add32(interval_total, beat.timestamp_us - last_pulse_ts);
        interval_count = sat_add32(interval_count, 32'd1);
      end
      last_pulse_ts = beat.timestamp_us;
      return 1'b0;
    end
    period = '0;
    speed  = '0;
    if (interval_count != 0) begin
      period = 64'(interval_total) / 64'(interval_count);
    end
    if (period != 0) begin
      divisor = 64'(ppnm_setting) * period;
      if (divisor == 0) begin
        speed = 64'(SPEED_MAX);
      end else begin
        speed = MM_PER_NMI_SCALED / divisor;
      end
      if (speed > 64'(SPEED_MAX)) begin
        speed = 64'(SPEED_MAX);
      end
    end
    report.speed_mm_per_s = speed[SPEED_W-1:0];
    report.mean_period_us = period[TS_W-1:0];
    report.pulses_counted = interval_count;
    interval_total = '0;
    interval_count = '0;
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result beat: speed %0d period %0d count %0d",
                   result_beat.speed_mm_per_s, result_beat.mean_period_us,
                   result_beat.pulses_counted);
        end
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (result_beat.speed_mm_per_s != want.speed_mm_per_s ||
            result_beat.mean_period_us != want.mean_period_us ||
            result_beat.pulses_counted != want.pulses_counted) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: speed %0d/%0d period %0d/%0d count %0d/%0d (exp/act)",
                     want.speed_mm_per_s, result_beat.speed_mm_per_s,
                     want.mean_period_us, result_beat.mean_period_us,
                     want.pulses_counted, result_beat.pulses_counted);
          end
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [TS_W-1:0] ts);
    in_item_t beat;
    result_t  report;
    beat.operation    = op;
    beat.timestamp_us = ts;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item_beat  <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    beats_sent++;
    if (advance_tach(beat, report)) begin
      pending_reports.push_back(report);
    end
  endtask

  task automatic wait_reports_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_reports.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ppnm(input logic [PPNM_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ppnm_setting = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TS_W-1:0] pick_interval();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom_range(200000, 20000);
    if (pick < 75) return $urandom_range(3000000, 200000);
    if (pick < 88) return $urandom_range(2000, 1);
    if (pick < 96) return $urandom_range(32'h7FFFFFFF, 3000000);
    return $urandom;
  endfunction

  task automatic send_wheel_run();
    int              pulses;
    logic [TS_W-1:0] base;
    pulses = $urandom_range(12, 1);
    base   = pick_interval();
    for (int i = 0; i < pulses; i++) begin
      if ($urandom_range(99) < 10) begin
        wheel_clock = $urandom;
      end else begin
        wheel_clock = wheel_clock + base + $urandom_range(base / 8);
      end
      send_item(OP_PULSE, wheel_clock);
    end
    send_item(OP_REPORT, $urandom);
    if ($urandom_range(99) < 8) begin
      send_item(OP_REPORT, $urandom);
    end
  endtask

  task automatic test_directed_cases();
    send_item(OP_REPORT, 32'h0);
    send_item(OP_PULSE, 32'h0);
    send_item(OP_PULSE, 32'hFFFFFFFF);
    send_item(OP_REPORT, 32'hFFFFFFFF);
    send_item(OP_PULSE, 32'd5);
    send_item(OP_PULSE, 32'd5);
    send_item(OP_PULSE, 32'd6);
    send_item(OP_REPORT, 32'hA5A5A5A5);
    send_item(OP_PULSE, 32'h0);
    send_item(OP_PULSE, 32'hF0000000);
    send_item(OP_PULSE, 32'h0);
    send_item(OP_PULSE, 32'hF0000000);
    send_item(OP_REPORT, 32'h5A5A5A5A);
    send_item(OP_PULSE, 32'd100);
    send_item(OP_REPORT, 32'd50);
    send_item(OP_PULSE, 32'd200);
    send_item(OP_REPORT, 32'h12345678);
    send_item(OP_PULSE, 32'd1000);
    send_item(OP_PULSE, 32'd101000);
    send_item(OP_PULSE, 32'd201000);
    send_item(OP_REPORT, 32'h0);
    wait_reports_drained();
  endtask

  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      wheel_clock = wheel_clock + pick_interval();
      send_item((i % 2 == 0) ? OP_PULSE : OP_REPORT, wheel_clock);
    end
    wait_reports_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [PPNM_W-1:0] ppnm, input int beats);
    int target;
    write_ppnm(ppnm);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    wheel_clock    = $urandom;
    target         = beats_sent + beats;
    while (beats_sent < target) begin
      send_wheel_run();
    end
    wait_reports_drained();
  endtask

  initial begin
    reset_tach();
    wheel_clock = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(0, 0, 16'd65535, 225);
    test_backpressure_fill();
    test_random_traffic(78, 0, 16'd1, 225);
    test_random_traffic(0, 78, 16'($urandom_range(65534, 2)), 225);
    test_random_traffic(17, 17, 16'd20000, 225);
    mismatches += pending_reports.size();
    $display("Run covered %0d item beats, %0d checked reports, %0d register writes.",
             beats_sent, reports_checked, cfg_writes);
    $display("Mismatches and missing results: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ppsm_pkg.sv
rtl/core/ppsm_front.sv
rtl/core/ppsm_queue.sv
rtl/core/ppsm_divider.sv
rtl/core/ppsm_back.sv
rtl/core/pulse_period_speed_meter.sv
tb/tb_top.sv
